// ===== rtl/rlde_pkg.sv =====
// Shared types, constants and BCD helpers for the run-length decimal encoder.
package rlde_pkg;

  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 17;
  localparam int COUNT_DIGITS = 5;
  localparam int CNT_W        = 4 * COUNT_DIGITS;
  localparam int REM_W        = $clog2(COUNT_DIGITS + 1);

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef logic [CNT_W-1:0] bcd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BYTE,
    S_DIGIT
  } state_t;

  // Largest run length: 10^COUNT_DIGITS - 1, capped at the 17-bit maximum.
  function automatic longint unsigned len_limit();
    longint unsigned lim;
    longint unsigned len_max;
    lim     = 1;
    len_max = (longint'(1) << LEN_W) - 1;
    for (int d = 0; d < COUNT_DIGITS; d++) begin
      if (lim <= len_max) begin
        lim = lim * 10;
      end
    end
    lim = lim - 1;
    if (lim > len_max) begin
      lim = len_max;
    end
    return lim;
  endfunction

  function automatic bcd_t to_bcd(longint unsigned v);
    bcd_t            res;
    longint unsigned w;
    res = '0;
    w   = v;
    for (int d = 0; d < COUNT_DIGITS; d++) begin
      res[4*d +: 4] = 4'(w % 10);
      w             = w / 10;
    end
    return res;
  endfunction

  localparam bcd_t CNT_LIMIT = to_bcd(len_limit());
  localparam bcd_t CNT_ONE   = bcd_t'(1);

  // Ripple increment of a BCD count, one digit per step.
  function automatic bcd_t bcd_inc(bcd_t v);
    bcd_t res;
    logic carry;
    res   = v;
    carry = 1'b1;
    for (int d = 0; d < COUNT_DIGITS; d++) begin
      if (carry) begin
        if (v[4*d +: 4] == 4'd9) begin
          res[4*d +: 4] = 4'd0;
        end else begin
          res[4*d +: 4] = v[4*d +: 4] + 4'd1;
          carry         = 1'b0;
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/rlde_in_if.sv =====
// Input channel: raw byte words with an end-of-stream mark.
interface rlde_in_if;
  logic                           valid;
  logic                           ready;
  logic [rlde_pkg::BYTE_W-1:0]    in_byte;
  logic                           stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

// ===== rtl/rlde_out_if.sv =====
// Result channel: encoded byte words with digit and framing flags.
interface rlde_out_if;
  logic                           valid;
  logic                           ready;
  logic [rlde_pkg::BYTE_W-1:0]    out_byte;
  logic                           is_digit;
  logic                           last;
  logic                           stream_done;

  modport source (output valid, output out_byte, output is_digit, output last,
                  output stream_done, input ready);
  modport sink   (input valid, input out_byte, input is_digit, input last,
                  input stream_done, output ready);
endinterface

// ===== rtl/run_length_decimal_encoder_top.sv =====
// Run-length encoder: emits run byte, then, for a run longer than one, its length as ASCII
// decimal digits shifted out of a BCD register MSD first, with leading zero digits skipped.
// Input is taken only in S_IDLE: a word that only extends or opens a run leaves the block
// ready for the next word; a closing or end-of-stream word holds off input until the serial
// BCD shift register has sent its results, and any output stall holds it off longer.
// Reset: synchronous active-low rst_n clears the sequencer, the output valid flag and the open run.
module run_length_decimal_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  rlde_in_if.sink    in_w,
  rlde_out_if.source out_w
);
  import rlde_pkg::*;

  state_t             state_r, state_nxt;

  logic [BYTE_W-1:0]  run_byte_r, run_byte_nxt;
  bcd_t               run_cnt_r, run_cnt_nxt;
  logic               run_act_r, run_act_nxt;

  logic [BYTE_W-1:0]  emit_byte_r, emit_byte_nxt;
  bcd_t               emit_cnt_r, emit_cnt_nxt;
  logic               emit_multi_r, emit_multi_nxt;
  logic               fin_r, fin_nxt;
  logic               done_r, done_nxt;
  logic               pend_r, pend_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               started_r, started_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_dig_r, out_dig_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_done_r, out_done_nxt;

  logic               adv;
  logic               acc;
  logic               same_byte;
  logic               close_run;
  bcd_t               inc_cnt;
  logic [3:0]         top_dig;
  logic               byte_fire;
  logic               dig_skip;
  logic               dig_fire;
  logic               run_end;

  assign adv       = !out_vld_r || out_w.ready;
  assign acc       = (state_r == S_IDLE) && in_w.valid;
  assign same_byte = run_act_r && (in_w.in_byte == run_byte_r);
  assign close_run = run_act_r && !same_byte;
  assign inc_cnt   = (run_cnt_r == CNT_LIMIT) ? run_cnt_r : bcd_inc(run_cnt_r);
  assign top_dig   = emit_cnt_r[CNT_W-1 -: 4];
  assign byte_fire = (state_r == S_BYTE) && adv;
  assign dig_skip  = (state_r == S_DIGIT) && !started_r && (top_dig == 4'd0);
  assign dig_fire  = (state_r == S_DIGIT) && !dig_skip && adv;
  assign run_end   = (byte_fire && !emit_multi_r) ||
                     (dig_fire && (rem_r == REM_W'(1)));

  assign in_w.ready        = (state_r == S_IDLE);
  assign out_w.valid       = out_vld_r;
  assign out_w.out_byte    = out_byte_r;
  assign out_w.is_digit    = out_dig_r;
  assign out_w.last        = out_last_r;
  assign out_w.stream_done = out_done_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && (close_run || in_w.stream_end)) begin
          state_nxt = S_BYTE;
        end
      end
      S_BYTE: begin
        if (byte_fire && emit_multi_r) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        state_nxt = S_DIGIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (run_end) begin
      state_nxt = pend_r ? S_BYTE : S_IDLE;
    end
  end

  always_comb begin
    run_byte_nxt   = run_byte_r;
    run_cnt_nxt    = run_cnt_r;
    run_act_nxt    = run_act_r;
    emit_byte_nxt  = emit_byte_r;
    emit_cnt_nxt   = emit_cnt_r;
    emit_multi_nxt = emit_multi_r;
    fin_nxt        = fin_r;
    done_nxt       = done_r;
    pend_nxt       = pend_r;
    rem_nxt        = rem_r;
    started_nxt    = started_r;
    out_vld_nxt    = out_vld_r && !out_w.ready;
    out_byte_nxt   = out_byte_r;
    out_dig_nxt    = out_dig_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (close_run) begin
            emit_byte_nxt  = run_byte_r;
            emit_cnt_nxt   = run_cnt_r;
            emit_multi_nxt = (run_cnt_r != CNT_ONE);
            fin_nxt        = !in_w.stream_end;
            done_nxt       = 1'b0;
            pend_nxt       = in_w.stream_end;
            run_byte_nxt   = in_w.in_byte;
            run_cnt_nxt    = CNT_ONE;
            run_act_nxt    = 1'b1;
          end else if (in_w.stream_end) begin
            // flush the run this word leaves open and drop back to no run
            emit_byte_nxt  = in_w.in_byte;
            emit_cnt_nxt   = same_byte ? inc_cnt : CNT_ONE;
            emit_multi_nxt = same_byte;
            fin_nxt        = 1'b1;
            done_nxt       = 1'b1;
            pend_nxt       = 1'b0;
            run_byte_nxt   = '0;
            run_cnt_nxt    = '0;
            run_act_nxt    = 1'b0;
          end else begin
            run_byte_nxt   = in_w.in_byte;
            run_cnt_nxt    = same_byte ? inc_cnt : CNT_ONE;
            run_act_nxt    = 1'b1;
          end
        end
      end
      S_BYTE: begin
        if (byte_fire) begin
          out_vld_nxt  = 1'b1;
          out_byte_nxt = emit_byte_r;
          out_dig_nxt  = 1'b0;
          out_last_nxt = !emit_multi_r && fin_r;
          out_done_nxt = !emit_multi_r && fin_r && done_r;
          rem_nxt      = REM_W'(COUNT_DIGITS);
          started_nxt  = 1'b0;
        end
      end
      S_DIGIT: begin
        if (dig_skip || dig_fire) begin
          // advance the BCD shift register by one digit
          emit_cnt_nxt = {emit_cnt_r[CNT_W-5:0], 4'd0};
          rem_nxt      = rem_r - REM_W'(1);
        end
        if (dig_fire) begin
          started_nxt  = 1'b1;
          out_vld_nxt  = 1'b1;
          out_byte_nxt = ASCII_ZERO | {4'd0, top_dig};
          out_dig_nxt  = 1'b1;
          out_last_nxt = (rem_r == REM_W'(1)) && fin_r;
          out_done_nxt = (rem_r == REM_W'(1)) && fin_r && done_r;
        end
      end
      default: begin
        out_vld_nxt = out_vld_r && !out_w.ready;
      end
    endcase

    // stream end after a closed run: flush the run still open
    if (run_end && pend_r) begin
      emit_byte_nxt  = run_byte_r;
      emit_cnt_nxt   = run_cnt_r;
      emit_multi_nxt = (run_cnt_r != CNT_ONE);
      fin_nxt        = 1'b1;
      done_nxt       = 1'b1;
      pend_nxt       = 1'b0;
      run_byte_nxt   = '0;
      run_cnt_nxt    = '0;
      run_act_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      run_byte_r <= '0;
      run_cnt_r  <= '0;
      run_act_r  <= 1'b0;
      pend_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      run_byte_r <= run_byte_nxt;
      run_cnt_r  <= run_cnt_nxt;
      run_act_r  <= run_act_nxt;
      pend_r     <= pend_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_byte_r  <= emit_byte_nxt;
    emit_cnt_r   <= emit_cnt_nxt;
    emit_multi_r <= emit_multi_nxt;
    fin_r        <= fin_nxt;
    done_r       <= done_nxt;
    rem_r        <= rem_nxt;
    started_r    <= started_nxt;
    out_byte_r   <= out_byte_nxt;
    out_dig_r    <= out_dig_nxt;
    out_last_r   <= out_last_nxt;
    out_done_r   <= out_done_nxt;
  end

endmodule
